FILE: design/dtp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtp_pkg;

  // Token buffer size and the width of the token length counter.
  localparam int TOKEN_BUFFER_LEN = 32;
  localparam int TL_W             = 6;
  localparam int CNT_W            = 16;
  localparam int QUEUE_DEPTH      = 4;

  // Length limits for a ten digit value.
  localparam int LONG_TOKEN_LEN = 11;
  localparam int TEN_TOKEN_LEN  = 10;

  // Character codes.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_NOT_DIGIT = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_RANGE_MIN = 1'b0;
  localparam logic CFG_RANGE_MAX = 1'b1;

  localparam logic signed [31:0] RANGE_MIN_RESET = 32'sh8000_0000;
  localparam logic signed [31:0] RANGE_MAX_RESET = 32'sh7FFF_FFFF;

  // Classified character as passed from the front end to the parser.
  typedef struct packed {
    logic       is_space;
    logic       is_nul;
    logic       is_digit;
    logic       is_minus;
    logic       is_zero;
    logic       ge_two;
    logic [3:0] digit;
  } chr_class_t;

endpackage

`default_nettype wire

FILE: design/dtp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dtp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface dtp_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] parsed_value;
  logic [15:0]        consumed;

  modport source (output valid, output status, output parsed_value, output consumed,
                  input ready);
  modport sink (input valid, input status, input parsed_value, input consumed,
                output ready);
endinterface

`default_nettype wire

FILE: design/dtp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dtp_front (
  dtp_char_if.sink            in_ch,
  output logic                push_valid,
  output dtp_pkg::chr_class_t push_data,
  input  logic                push_ready
);

  // Classify the incoming byte so that the parser only sees flags. For the
  // digit characters the low nibble of the code is the digit value itself.
  always_comb begin
    push_data.is_space  = (in_ch.char_in == dtp_pkg::CHAR_SPACE);
    push_data.is_nul    = (in_ch.char_in == dtp_pkg::CHAR_NUL);
    push_data.is_digit  = (in_ch.char_in >= dtp_pkg::CHAR_ZERO) &&
                          (in_ch.char_in <= dtp_pkg::CHAR_NINE);
    push_data.is_minus  = (in_ch.char_in == dtp_pkg::CHAR_MINUS);
    push_data.is_zero   = (in_ch.char_in == dtp_pkg::CHAR_ZERO);
    push_data.ge_two    = (in_ch.char_in >= dtp_pkg::CHAR_TWO);
    push_data.digit     = in_ch.char_in[3:0];
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

`default_nettype wire

FILE: design/dtp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dtp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  dtp_pkg::chr_class_t push_data,
  output logic                push_ready,
  output logic                pop_valid,
  output dtp_pkg::chr_class_t pop_data,
  input  logic                pop_ready
);

  localparam int PTR_W = $clog2(dtp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(dtp_pkg::QUEUE_DEPTH + 1);

  dtp_pkg::chr_class_t entries [dtp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                push;
  logic                pop;

  assign push_ready = (count != CNT_W'(dtp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(dtp_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not rise on push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - CNT_W'(1))
    else $error("queue count did not fall on pop");
`endif

endmodule

`default_nettype wire

FILE: design/dtp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dtp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  input  dtp_pkg::chr_class_t pop_data,
  output logic                pop_ready,
  input  logic signed [31:0]  range_min,
  input  logic signed [31:0]  range_max,
  dtp_result_if.source        out_ch
);

  localparam int TL_W  = dtp_pkg::TL_W;
  localparam int CNT_W = dtp_pkg::CNT_W;

  // Parser state.
  logic             in_token;
  logic [CNT_W-1:0] char_count;
  logic [TL_W-1:0]  token_length;
  logic             first_minus;
  logic             first_zero;
  logic             first_ge_two;
  logic             second_is_zero;
  logic             bad_digit_seen;
  logic [31:0]      magnitude_acc;

  // Output register.
  logic               out_valid;
  logic [2:0]         out_status;
  logic signed [31:0] out_value;
  logic [CNT_W-1:0]   out_consumed;

  logic                     emits;
  logic [2:0]               res_status;
  logic signed [31:0]       res_value;
  logic [CNT_W-1:0]         res_consumed;
  logic                     take_char;
  logic                     do_finish;
  logic [CNT_W-1:0]         count_bumped;
  logic [TL_W-1:0]          length_next;
  logic [31:0]              magnitude_next;
  logic signed [32:0]       value_wide;
  logic                     pop;

  always_comb begin
    count_bumped   = (char_count != {CNT_W{1'b1}}) ? char_count + CNT_W'(1) : char_count;
    length_next    = token_length + TL_W'(1);
    magnitude_next = (magnitude_acc << 3) + (magnitude_acc << 1) +
                     {28'd0, pop_data.digit};
    value_wide     = first_minus ? -$signed({1'b0, magnitude_acc})
                                 : $signed({1'b0, magnitude_acc});

    take_char    = 1'b0;
    do_finish    = 1'b0;
    emits        = 1'b0;
    res_status   = dtp_pkg::ST_OK;
    res_value    = '0;
    res_consumed = char_count;

    if (!in_token) begin
      if (pop_data.is_nul) begin
        emits      = 1'b1;
        res_status = dtp_pkg::ST_EMPTY;
      end else if (!pop_data.is_space) begin
        take_char = 1'b1;
      end
    end else if (pop_data.is_space || pop_data.is_nul) begin
      do_finish = 1'b1;
    end else begin
      take_char = 1'b1;
    end

    if (take_char && (length_next >= TL_W'(dtp_pkg::TOKEN_BUFFER_LEN))) begin
      emits        = 1'b1;
      res_status   = dtp_pkg::ST_OVERFLOW;
      res_consumed = count_bumped;
    end

    if (do_finish) begin
      emits = 1'b1;
      if (bad_digit_seen) begin
        res_status = dtp_pkg::ST_NOT_DIGIT;
      end else if ((first_zero && token_length > TL_W'(1)) ||
                   (first_minus && token_length > TL_W'(1) && second_is_zero)) begin
        res_status = dtp_pkg::ST_INVALID;
      end else if ((token_length >= TL_W'(dtp_pkg::LONG_TOKEN_LEN)) ||
                   (first_ge_two && token_length == TL_W'(dtp_pkg::TEN_TOKEN_LEN))) begin
        res_status = dtp_pkg::ST_INVALID;
      end else if ((value_wide < $signed({range_min[31], range_min})) ||
                   (value_wide > $signed({range_max[31], range_max}))) begin
        res_status = dtp_pkg::ST_INVALID;
      end else begin
        res_status = dtp_pkg::ST_OK;
        res_value  = value_wide[31:0];
      end
    end
  end

  // A character that leaves no result may go ahead even while a result waits.
  assign pop_ready = !emits || !out_valid || out_ch.ready;
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token       <= 1'b0;
      char_count     <= '0;
      token_length   <= '0;
      first_minus    <= 1'b0;
      first_zero     <= 1'b0;
      first_ge_two   <= 1'b0;
      second_is_zero <= 1'b0;
      bad_digit_seen <= 1'b0;
      magnitude_acc  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (pop && emits) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (emits) begin
          in_token       <= 1'b0;
          char_count     <= '0;
          token_length   <= '0;
          first_minus    <= 1'b0;
          first_zero     <= 1'b0;
          first_ge_two   <= 1'b0;
          second_is_zero <= 1'b0;
          bad_digit_seen <= 1'b0;
          magnitude_acc  <= '0;
        end else if (take_char) begin
          in_token     <= 1'b1;
          char_count   <= count_bumped;
          token_length <= length_next;
          if (token_length == '0) begin
            first_minus  <= pop_data.is_minus;
            first_zero   <= pop_data.is_zero;
            first_ge_two <= pop_data.ge_two;
          end
          if (token_length == TL_W'(1) && pop_data.is_zero) begin
            second_is_zero <= 1'b1;
          end
          if (pop_data.is_digit) begin
            magnitude_acc <= magnitude_next;
          end else if (!(token_length == '0 && pop_data.is_minus)) begin
            bad_digit_seen <= 1'b1;
          end
        end else begin
          // Leading space.
          char_count <= count_bumped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      out_status   <= res_status;
      out_value    <= res_value;
      out_consumed <= res_consumed;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.parsed_value = out_value;
  assign out_ch.consumed     = out_consumed;

`ifndef NO_ASSERTIONS
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != dtp_pkg::ST_OK) |-> out_value == '0)
    else $error("non-zero value with failing status");
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    token_length < TL_W'(dtp_pkg::TOKEN_BUFFER_LEN))
    else $error("token length reached buffer size");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (pop && emits) |=> (!in_token && token_length == '0 && char_count == '0 && out_valid))
    else $error("parser did not restart after a result");
`endif

endmodule

`default_nettype wire

FILE: design/decimal_token_parse_range_check.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Word                                   Accepted when
// in_ch     in         char_in (8 bit text byte)              valid && ready
// out_ch    out        status, parsed_value, consumed          valid && ready
// cfg       in         cfg_index selects range_min/range_max   cfg_we high
//
// The queue in front of the parser holds four classified bytes, so the block
// takes one text byte every cycle while not full, even while a result waits.
// The parser handles one byte a cycle unless a pending result holds it back;
// it multiplies by ten with a shift-add and registers each result word.
// Reset is synchronous: it empties the queue, restarts the parser, drops any
// pending result and returns the range registers to their full span.
// A stalled result stalls only bytes that would themselves yield a result.
module decimal_token_parse_range_check (
  input  logic         clk,
  input  logic         rst,
  dtp_char_if.sink     in_ch,
  dtp_result_if.source out_ch,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  // Inclusive acceptance range.
  logic signed [31:0] range_min;
  logic signed [31:0] range_max;

  logic                push_valid;
  logic                push_ready;
  dtp_pkg::chr_class_t push_data;
  logic                pop_valid;
  logic                pop_ready;
  dtp_pkg::chr_class_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= dtp_pkg::RANGE_MIN_RESET;
      range_max <= dtp_pkg::RANGE_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtp_pkg::CFG_RANGE_MIN: range_min <= $signed(cfg_data);
        dtp_pkg::CFG_RANGE_MAX: range_max <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // The front end classifies each byte as it arrives.
  dtp_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // The short queue lets the input side run while the output is stalled.
  dtp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // The parser tracks the token, checks it and registers the result word.
  dtp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .range_min (range_min),
    .range_max (range_max),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
